FILE: rtl/bdd_pkg.sv
// Shared types and constants for the bounded deque with delete-by-value.
package bdd_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int VALUE_W      = 32;
    localparam int KIND_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 7;

    // operation codes carried in the kind field
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_BACK  = 2'd1,
        KIND_REMOVE     = 2'd2
    } kind_t;

    // status codes returned with each result
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // engine sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FINISH
    } state_t;

    // one finished result handed from the engine to the output stage
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } result_t;

endpackage

FILE: rtl/bdd_req_if.sv
// Request channel: operation kind and value, valid/ready handshake.
interface bdd_req_if import bdd_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);

endinterface

FILE: rtl/bdd_rsp_if.sv
// Response channel: status and count, valid/ready handshake.
interface bdd_rsp_if import bdd_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, output status, output count, input ready);
    modport sink   (input valid, input status, input count, output ready);

endinterface

FILE: rtl/bdd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bdd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, read data registered while re is high
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/bdd_engine.sv
// Operation sequencer: ring pointers, push handling, search-and-compact over the slot RAM.
module bdd_engine import bdd_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // incoming operation
    input  logic                        item_valid,
    output logic                        item_ready,
    input  logic [KIND_W-1:0]           item_kind,
    input  logic [VALUE_W-1:0]          item_value,
    // finished result
    output logic                        res_valid,
    input  logic                        res_ready,
    output result_t                     res,
    // slot RAM
    output logic                        mem_we,
    output logic [$clog2(CAPACITY)-1:0] mem_waddr,
    output logic [VALUE_W-1:0]          mem_wdata,
    output logic                        mem_re,
    output logic [$clog2(CAPACITY)-1:0] mem_raddr,
    input  logic [VALUE_W-1:0]          mem_rdata
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int OCC_W = $clog2(CAPACITY + 1);

    state_t              state_reg, state_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic [IDX_W-1:0]    front_reg, front_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;
    logic [OCC_W-1:0]    rd_off_reg, rd_off_next;
    logic [IDX_W-1:0]    cmp_off_reg, cmp_off_next;
    logic                found_reg, found_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic                full;
    logic                match;
    logic                last_entry;
    logic [OCC_W+COUNT_W-1:0] count_ext;

    // front plus offset, wrapped to the ring size
    function automatic logic [IDX_W-1:0] ring_pos(
        input logic [IDX_W-1:0] base,
        input logic [IDX_W-1:0] off
    );
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IDX_W+1)'(CAPACITY))
        begin
            sum = sum - (IDX_W+1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign full       = (occ_reg == OCC_W'(CAPACITY));
    assign match      = (mem_rdata == value_reg);
    assign last_entry = (OCC_W'(cmp_off_reg) == occ_reg - OCC_W'(1));

    // count field is the occupancy truncated to seven bits
    assign count_ext  = {{COUNT_W{1'b0}}, occ_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (kind_reg == KIND_REMOVE && occ_reg != '0)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                if (last_entry)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        kind_next    = kind_reg;
        value_next   = value_reg;
        front_next   = front_reg;
        occ_next     = occ_reg;
        rd_off_next  = rd_off_reg;
        cmp_off_next = cmp_off_reg;
        found_next   = found_reg;
        status_next  = status_reg;
        item_ready   = 1'b0;
        res_valid    = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = ring_pos(front_reg, IDX_W'(0));
        mem_wdata    = value_reg;
        mem_re       = 1'b0;
        mem_raddr    = ring_pos(front_reg, IDX_W'(0));

        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    kind_next  = item_kind;
                    value_next = item_value;
                end
            end
            S_EXEC:
            begin
                status_next = ST_DONE;
                unique case (kind_reg)
                    KIND_PUSH_FRONT:
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            front_next = (front_reg == '0) ? IDX_W'(CAPACITY - 1)
                                                          : front_reg - IDX_W'(1);
                            mem_we     = 1'b1;
                            mem_waddr  = front_next;
                            occ_next   = occ_reg + OCC_W'(1);
                        end
                    end
                    KIND_PUSH_BACK:
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = ring_pos(front_reg, occ_reg[IDX_W-1:0]);
                            occ_next  = occ_reg + OCC_W'(1);
                        end
                    end
                    KIND_REMOVE:
                    begin
                        if (occ_reg == '0)
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                        else
                        begin
                            // first read at the front, scan starts next cycle
                            mem_re       = 1'b1;
                            mem_raddr    = ring_pos(front_reg, IDX_W'(0));
                            rd_off_next  = OCC_W'(1);
                            cmp_off_next = '0;
                            found_next   = 1'b0;
                        end
                    end
                    default:
                    begin
                        // unused code: no change, status done
                        status_next = ST_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                // keep one read in flight ahead of the compare
                if (rd_off_reg < occ_reg)
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = ring_pos(front_reg, rd_off_reg[IDX_W-1:0]);
                    rd_off_next = rd_off_reg + OCC_W'(1);
                end
                cmp_off_next = cmp_off_reg + IDX_W'(1);

                // past the hit, move each entry one place toward the front
                if (found_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ring_pos(front_reg, cmp_off_reg - IDX_W'(1));
                    mem_wdata = mem_rdata;
                end
                else if (match)
                begin
                    found_next = 1'b1;
                end

                if (last_entry)
                begin
                    if (found_reg || match)
                    begin
                        occ_next    = occ_reg - OCC_W'(1);
                        status_next = ST_DONE;
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                end
            end
            S_FINISH:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    assign res.status = status_reg;
    assign res.count  = count_ext[COUNT_W-1:0];

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            occ_reg   <= occ_next;
        end
    end

    // operation payload and scan bookkeeping
    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        value_reg   <= value_next;
        rd_off_reg  <= rd_off_next;
        cmp_off_reg <= cmp_off_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
    end

endmodule

FILE: rtl/bounded_deque_with_delete.sv
// Bounded deque with delete-by-value: the request/response channels and output register.
//
// Usage:
//   req carries one operation per transfer: kind 0 pushes value at the front,
//   kind 1 pushes it at the back, kind 2 removes the first entry from the front
//   equal to value and closes the gap. Kind 3 changes nothing.
//   rsp returns one transfer per operation: status (0 done, 1 no match,
//   2 push refused because full) and the count held afterwards (low 7 bits).
// Sequencing:
//   One operation is in work at a time. A push passes from its req transfer through
//   the execute and finish states to the output register, and req is ready again
//   once the engine is back in idle; a removal reads every held entry through the
//   one read port of the slot RAM, writing back the shifted entries as it goes.
//   A removal on an empty store goes straight from execute to finish, with no scan.
// Reset:
//   rst_n clears the front pointer and the count; the store is empty at once.
// Stalls:
//   A result waits in the output register while rsp.ready is low; the next
//   operation is still taken and runs until its own result is ready, then
//   holds until the register frees up.
module bounded_deque_with_delete import bdd_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic      clk,
    input  logic      rst_n,
    bdd_req_if.sink   req,
    bdd_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(CAPACITY);

    logic               res_valid;
    logic               res_ready;
    result_t            res;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;

    logic               rsp_valid_reg, rsp_valid_next;
    result_t            rsp_data_reg;

    bdd_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (req.valid),
        .item_ready (req.ready),
        .item_kind  (req.kind),
        .item_value (req.value),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    bdd_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register: free when empty or being drained this cycle
    assign res_ready = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.status = rsp_data_reg.status;
    assign rsp.count  = rsp_data_reg.count;

endmodule

FILE: dv/tb_bounded_deque_with_delete.sv
// Testbench for the bounded deque with delete-by-value: directed table, random phases, scoreboard.
`timescale 1ns / 1ps

module tb_bounded_deque_with_delete;
    import bdd_pkg::*;

    localparam int CAPACITY    = DEF_CAPACITY;
    localparam int IDLE_PCT    = 31;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = CAPACITY + 16;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int NUM_DIR     = 22;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 110;

    // kind code 3 is not an operation; the block must treat it as a no-op
    localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        int                 reps;    // repeat count, value increments per repeat
        bit                 typed;   // expected result given in the row
        status_t            status;
        logic [COUNT_W-1:0] count;
    } dir_row_t;

    logic clk;
    logic rst_n;

    bdd_req_if req_if ();
    bdd_rsp_if rsp_if ();

    bounded_deque_with_delete #(.CAPACITY(CAPACITY)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // shadow copy of the held sequence, front at index 0
    logic [VALUE_W-1:0] deque_shadow [$];
    result_t            pending_results [$];

    bit no_idle;
    bit hold_request;
    int cycle_count;
    int error_count;
    int rsp_count;
    int push_ok, push_full, remove_hit, remove_miss, nop_count, peak_count;

    logic [VALUE_W-1:0] value_pool [8];
    logic [VALUE_W-1:0] edge_values [4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                            32'h8000_0000, 32'h7FFF_FFFF};
    int push_bias [NUM_PHASES] = '{15, 50, 85, 15, 50, 85};

    // directed rows: empty, extremes, middle/front/back removal, full, no-op
    dir_row_t dir_rows [NUM_DIR] = '{
        '{KIND_REMOVE,     32'h0000_0005,  1, 1'b1, ST_NOT_FOUND, 7'd0},
        '{KIND_NOP,        32'hFFFF_FFFF,  1, 1'b1, ST_DONE,      7'd0},
        '{KIND_PUSH_FRONT, 32'h8000_0000,  1, 1'b1, ST_DONE,      7'd1},
        '{KIND_PUSH_BACK,  32'h7FFF_FFFF,  1, 1'b1, ST_DONE,      7'd2},
        '{KIND_PUSH_FRONT, 32'hFFFF_FFFF,  1, 1'b1, ST_DONE,      7'd3},
        '{KIND_PUSH_BACK,  32'h0000_0000,  1, 1'b1, ST_DONE,      7'd4},
        '{KIND_PUSH_BACK,  32'hFFFF_FFFF,  1, 1'b1, ST_DONE,      7'd5},
        '{KIND_REMOVE,     32'h7FFF_FFFF,  1, 1'b0, ST_DONE,      7'd0},
        '{KIND_REMOVE,     32'h7FFF_FFFF,  1, 1'b1, ST_NOT_FOUND, 7'd4},
        '{KIND_REMOVE,     32'hFFFF_FFFF,  1, 1'b0, ST_DONE,      7'd0},
        '{KIND_REMOVE,     32'hFFFF_FFFE,  1, 1'b0, ST_DONE,      7'd0},
        '{KIND_NOP,        32'h5555_5555,  1, 1'b0, ST_DONE,      7'd0},
        '{KIND_REMOVE,     32'h0000_0000,  1, 1'b0, ST_DONE,      7'd0},
        '{KIND_REMOVE,     32'hFFFF_FFFF,  1, 1'b0, ST_DONE,      7'd0},
        '{KIND_REMOVE,     32'h8000_0000,  1, 1'b1, ST_DONE,      7'd0},
        '{KIND_PUSH_BACK,  32'h1000_0000, 64, 1'b0, ST_DONE,      7'd0},
        '{KIND_PUSH_FRONT, 32'h1234_5678,  1, 1'b1, ST_FULL,      7'd64},
        '{KIND_PUSH_BACK,  32'hFFFF_FFFF,  1, 1'b1, ST_FULL,      7'd64},
        '{KIND_NOP,        32'h0000_0000,  1, 1'b1, ST_DONE,      7'd64},
        '{KIND_REMOVE,     32'h1000_003F,  1, 1'b0, ST_DONE,      7'd0},
        '{KIND_PUSH_FRONT, 32'hDEAD_BEEF,  1, 1'b0, ST_DONE,      7'd0},
        '{KIND_REMOVE,     32'hDEAD_BEEF,  1, 1'b1, ST_DONE,      7'd63}
    };

    // apply one operation to the shadow sequence and return its result
    function automatic result_t deque_apply(input logic [KIND_W-1:0] op,
                                            input logic [VALUE_W-1:0] value);
        result_t res;
        int      hit;
        res.status = ST_DONE;
        hit        = -1;
        case (op)
            KIND_PUSH_FRONT, KIND_PUSH_BACK:
            begin
                if (deque_shadow.size() >= CAPACITY)
                begin
                    res.status = ST_FULL;
                    push_full++;
                end
                else
                begin
                    if (op == KIND_PUSH_FRONT)
                        deque_shadow.push_front(value);
                    else
                        deque_shadow.push_back(value);
                    push_ok++;
                end
            end
            KIND_REMOVE:
            begin
                for (int i = 0; i < deque_shadow.size() && hit < 0; i++)
                    if (deque_shadow[i] == value)
                        hit = i;
                if (hit < 0)
                begin
                    res.status = ST_NOT_FOUND;
                    remove_miss++;
                end
                else
                begin
                    deque_shadow.delete(hit);
                    remove_hit++;
                end
            end
            default:
                nop_count++;
        endcase
        res.count = COUNT_W'(deque_shadow.size());
        if (deque_shadow.size() > peak_count)
            peak_count = deque_shadow.size();
        return res;
    endfunction

    // random value: pool hits, full random, extremes, near misses
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(9))
            5, 6, 7: v = $urandom;
            8:       v = edge_values[$urandom_range(3)];
            9:       v = value_pool[$urandom_range(7)] ^ (32'h1 << $urandom_range(31));
            default: v = value_pool[$urandom_range(7)];
        endcase
        return v;
    endfunction

    task automatic note_mismatch(input string field, input int expv, input int actv);
        if (error_count < 10)
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, field,
                     expv, actv);
        error_count++;
    endtask

    // offer one transfer, wait for acceptance, then record what must come back
    task automatic offer_item(input logic [KIND_W-1:0] op, input logic [VALUE_W-1:0] value,
                              input bit typed, input result_t typed_res);
        result_t predicted;
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.kind  <= op;
        req_if.value <= value;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        predicted = deque_apply(op, value);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 pending_results.size());
        $display("TB_ERROR");
        $finish;
    end

    // response side: random back-pressure plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // scoreboard: each result against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            rsp_count++;
            if (pending_results.size() == 0)
                note_mismatch("unexpected result, status", -1, rsp_if.status);
            else
            begin
                want = pending_results.pop_front();
                if (rsp_if.status !== want.status)
                    note_mismatch("status", want.status, rsp_if.status);
                if (rsp_if.count !== want.count)
                    note_mismatch("count", want.count, rsp_if.count);
            end
        end
    end

    // stimulus
    initial
    begin
        logic [KIND_W-1:0]  op;
        logic [VALUE_W-1:0] value;
        result_t            typed_res;
        int                 roll;
        int                 push_cut;

        no_idle      = 1'b0;
        hold_request = 1'b0;
        error_count  = 0;
        rsp_count    = 0;
        push_ok      = 0;
        push_full    = 0;
        remove_hit   = 0;
        remove_miss  = 0;
        nop_count    = 0;
        peak_count   = 0;
        rst_n        <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.kind  <= KIND_NOP;
        req_if.value <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_rows[r])
            for (int k = 0; k < dir_rows[r].reps; k++)
            begin
                typed_res.status = dir_rows[r].status;
                typed_res.count  = dir_rows[r].count;
                offer_item(dir_rows[r].kind, dir_rows[r].value + k, dir_rows[r].typed,
                           typed_res);
            end

        // random phases sweep from draining through balanced to filling, twice
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            no_idle = (p == 4);
            if (p == 2)
                hold_request = 1'b1;
            foreach (value_pool[i])
                value_pool[i] = $urandom;
            push_cut = 4 + push_bias[p] * 96 / 100;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(99);
                if (roll < 4)
                begin
                    op    = KIND_NOP;
                    value = $urandom;
                end
                else if (roll < push_cut)
                begin
                    op    = $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
                    value = pick_value();
                end
                else
                begin
                    op = KIND_REMOVE;
                    if (deque_shadow.size() > 0 && $urandom_range(99) < 65)
                        value = deque_shadow[$urandom_range(deque_shadow.size() - 1)];
                    else
                        value = pick_value();
                end
                offer_item(op, value, 1'b0, typed_res);
            end
        end
        req_if.valid <= 1'b0;

        // drain, then allow a removal's worth of cycles for stray results
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d results checked: %0d pushes, %0d refused as full, %0d removals,",
                 rsp_count, push_ok, push_full, remove_hit);
        $display("%0d removals without match, %0d no-ops, peak count %0d, %0d mismatches",
                 remove_miss, nop_count, peak_count, error_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/bdd_pkg.sv
rtl/bdd_req_if.sv
rtl/bdd_rsp_if.sv
rtl/bdd_ram.sv
rtl/bdd_engine.sv
rtl/bounded_deque_with_delete.sv
dv/tb_bounded_deque_with_delete.sv
